// File: rtl/adjacency_matrix_edge_table_assert.svh
// ----------------------------------------------------------------------------
// adjacency_matrix_edge_table_assert.svh
// assertion macros shared by the edge table checker
// ----------------------------------------------------------------------------
`ifndef ADJACENCY_MATRIX_EDGE_TABLE_ASSERT_SVH
`define ADJACENCY_MATRIX_EDGE_TABLE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define AMET_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define AMET_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/amet_pkg.sv
// ----------------------------------------------------------------------------
// amet_pkg
// types, codes and helpers of the adjacency matrix edge table
// ----------------------------------------------------------------------------
package amet_pkg;

    // graph size and stored cost width
    localparam int MAX_NODES  = 16;
    localparam int COST_WIDTH = 16;

    // node fields on the stream are four bits wide
    localparam int NODE_FIELD_MAX = 16;
    localparam int NODE_W         = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int ADDR_W         = 2 * NODE_W;
    localparam int MEM_DEPTH      = 1 << ADDR_W;

    localparam logic [4:0] EFF_MAX = 5'((MAX_NODES < NODE_FIELD_MAX) ?
                                        MAX_NODES : NODE_FIELD_MAX);
    localparam logic [4:0] NODE_COUNT_RST = 5'd16;

    typedef enum logic [2:0] {
        FN_INSERT = 3'd0,
        FN_REMOVE = 3'd1,
        FN_TEST   = 3'd2,
        FN_INDEG  = 3'd3,
        FN_OUTDEG = 3'd4,
        FN_LIST   = 3'd5
    } t_func;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_ABSENT   = 3'd2,
        ST_REPLACED = 3'd3,
        ST_NONE     = 3'd4
    } t_status;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_SCAN,
        S_FINAL
    } t_state;

    // one result word
    typedef struct packed {
        t_status     status;
        logic        is_edge;
        logic [4:0]  degree;
        logic [3:0]  nb_node;
        logic [15:0] nb_cost;
        logic        last;
    } t_result;

    // store access from the sequencer
    typedef struct packed {
        logic                  rd_en;
        logic [ADDR_W-1:0]     rd_addr;
        logic                  wr_en;
        logic [ADDR_W-1:0]     wr_addr;
        logic [COST_WIDTH-1:0] wr_data;
    } t_mem_req;

    // node count in use, limited by the graph size and the node field
    function automatic logic [4:0] eff_count(logic [4:0] v);
        return (v > EFF_MAX) ? EFF_MAX : v;
    endfunction

    function automatic logic [NODE_W-1:0] node_idx(logic [4:0] x);
        return NODE_W'(x);
    endfunction

    // row-major entry address
    function automatic logic [ADDR_W-1:0] cell_addr(logic [NODE_W-1:0] row,
                                                    logic [NODE_W-1:0] col);
        return {row, col};
    endfunction

    // input cost sign-extended or truncated to the stored width
    function automatic logic [COST_WIDTH-1:0] store_cost(logic signed [15:0] c);
        return COST_WIDTH'(c);
    endfunction

    // stored cost sign-extended back, truncated to the field width
    function automatic logic [15:0] out_cost(logic [COST_WIDTH-1:0] x);
        logic signed [COST_WIDTH-1:0] xs;
        xs = x;
        return 16'(xs);
    endfunction

endpackage

// File: rtl/amet_store.sv
// ----------------------------------------------------------------------------
// amet_store
// edge cost memory, one write and one registered read port, valid bits
// ----------------------------------------------------------------------------
module amet_store (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  amet_pkg::t_mem_req                  i_req,
    output logic [amet_pkg::COST_WIDTH-1:0]     o_rd_data
);
    import amet_pkg::*;

    logic [COST_WIDTH-1:0] r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]  r_vld;
    logic [COST_WIDTH-1:0] r_rd_data;

    // cost array write
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // an entry never written reads as no edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.wr_en) begin
            r_vld[i_req.wr_addr] <= 1'b1;
        end
    end

    // registered read, held while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_vld[i_req.rd_addr] ? r_mem[i_req.rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/amet_outreg.sv
// ----------------------------------------------------------------------------
// amet_outreg
// result output register between the sequencer and the master stream
// ----------------------------------------------------------------------------
module amet_outreg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  amet_pkg::t_result i_res,
    output logic              o_can_push,
    output logic              o_valid,
    input  logic              i_ready,
    output amet_pkg::t_result o_res
);
    import amet_pkg::*;

    logic    r_valid;
    t_result r_res;

    // room when empty or when the held word leaves this cycle
    assign o_can_push = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: rtl/amet_ctrl.sv
// ----------------------------------------------------------------------------
// amet_ctrl
// operation sequencer: read-modify-write of one entry, or a row/column scan
// ----------------------------------------------------------------------------
module amet_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [2:0]                      i_func,
    input  logic [3:0]                      i_src,
    input  logic [3:0]                      i_dst,
    input  logic [15:0]                     i_cost,
    input  logic [4:0]                      i_eff_n,
    output amet_pkg::t_mem_req              o_mem,
    input  logic [amet_pkg::COST_WIDTH-1:0] i_rd_data,
    output logic                            o_push,
    output amet_pkg::t_result               o_res,
    input  logic                            i_can_push
);
    import amet_pkg::*;

    t_state      r_state, n_state;
    t_func       r_func, n_func;
    logic [3:0]  r_src, n_src;
    logic [3:0]  r_dst, n_dst;
    logic [15:0] r_cost, n_cost;
    logic [4:0]  r_idx, n_idx;
    logic        r_chk, n_chk;
    logic [3:0]  r_chk_idx, n_chk_idx;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_pend, n_pend;
    logic [3:0]  r_pend_node, n_pend_node;
    logic [15:0] r_pend_cost, n_pend_cost;
    t_result     r_res, n_res;

    logic w_u_ok, w_v_ok;
    logic w_scan_more, w_hit, w_need_push, w_stall, w_scan_end, w_old_nz;
    logic w_row_scan;

    // node checks on the incoming word
    assign w_u_ok = {1'b0, i_src} < i_eff_n;
    assign w_v_ok = {1'b0, i_dst} < i_eff_n;

    // scan bookkeeping
    assign w_scan_more = r_idx < i_eff_n;
    assign w_hit       = r_chk && (i_rd_data != '0);
    assign w_need_push = (r_func == FN_LIST) && w_hit && r_pend;
    assign w_stall     = w_need_push && !i_can_push;
    assign w_scan_end  = !w_scan_more && !r_chk;
    assign w_old_nz    = i_rd_data != '0;
    assign w_row_scan  = (r_func == FN_OUTDEG) || (r_func == FN_LIST);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (t_func'(i_func)) inside
                        FN_INSERT, FN_REMOVE, FN_TEST: begin
                            n_state = (w_u_ok && w_v_ok) ? S_READ : S_FINAL;
                        end
                        FN_INDEG, FN_OUTDEG, FN_LIST: begin
                            n_state = w_u_ok ? S_SCAN : S_FINAL;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_can_push) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (w_scan_end) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                if (i_can_push) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb begin
        n_func      = r_func;
        n_src       = r_src;
        n_dst       = r_dst;
        n_cost      = r_cost;
        n_idx       = r_idx;
        n_chk       = r_chk;
        n_chk_idx   = r_chk_idx;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        n_pend_node = r_pend_node;
        n_pend_cost = r_pend_cost;
        n_res       = r_res;
        o_in_ready  = 1'b0;
        o_mem       = '0;
        o_push      = 1'b0;
        o_res       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_func       = t_func'(i_func);
                    n_src        = i_src;
                    n_dst        = i_dst;
                    n_cost       = i_cost;
                    n_idx        = '0;
                    n_chk        = 1'b0;
                    n_cnt        = '0;
                    n_pend       = 1'b0;
                    // taken only on a node check failure
                    n_res        = '0;
                    n_res.status = ST_INVALID;
                    n_res.last   = 1'b1;
                end
            end
            S_READ: begin
                o_mem.rd_en   = 1'b1;
                o_mem.rd_addr = cell_addr(node_idx({1'b0, r_src}),
                                          node_idx({1'b0, r_dst}));
            end
            S_EXEC: begin
                // modify and write back together with the result push
                o_push        = i_can_push;
                o_res.last    = 1'b1;
                o_mem.wr_addr = cell_addr(node_idx({1'b0, r_src}),
                                          node_idx({1'b0, r_dst}));
                unique case (r_func) inside
                    FN_INSERT: begin
                        o_mem.wr_en   = i_can_push;
                        o_mem.wr_data = store_cost(r_cost);
                        o_res.status  = w_old_nz ? ST_REPLACED : ST_OK;
                    end
                    FN_REMOVE: begin
                        o_mem.wr_en   = i_can_push && w_old_nz;
                        o_mem.wr_data = '0;
                        o_res.status  = w_old_nz ? ST_OK : ST_ABSENT;
                    end
                    default: begin
                        o_res.status  = ST_OK;
                        o_res.is_edge = w_old_nz;
                    end
                endcase
            end
            S_SCAN: begin
                // previous neighbour goes out once a later one is found
                o_push         = w_need_push && i_can_push;
                o_res.status   = ST_OK;
                o_res.nb_node  = r_pend_node;
                o_res.nb_cost  = r_pend_cost;
                o_res.last     = 1'b0;
                if (!w_stall) begin
                    // issue the next read while checking the previous one
                    if (w_scan_more) begin
                        o_mem.rd_en   = 1'b1;
                        o_mem.rd_addr = w_row_scan ?
                            cell_addr(node_idx({1'b0, r_src}), node_idx(r_idx)) :
                            cell_addr(node_idx(r_idx), node_idx({1'b0, r_src}));
                        n_idx         = r_idx + 5'd1;
                        n_chk         = 1'b1;
                        n_chk_idx     = r_idx[3:0];
                    end else begin
                        n_chk = 1'b0;
                    end
                    if (w_hit) begin
                        n_cnt       = r_cnt + 5'd1;
                        n_pend      = 1'b1;
                        n_pend_node = r_chk_idx;
                        n_pend_cost = out_cost(i_rd_data);
                    end
                end
                // closing word of a degree query or a listing
                if (w_scan_end) begin
                    n_res      = '0;
                    n_res.last = 1'b1;
                    if (r_func == FN_LIST) begin
                        if (r_pend) begin
                            n_res.status  = ST_OK;
                            n_res.nb_node = r_pend_node;
                            n_res.nb_cost = r_pend_cost;
                        end else begin
                            n_res.status  = ST_NONE;
                        end
                    end else begin
                        n_res.status = ST_OK;
                        n_res.degree = r_cnt;
                    end
                end
            end
            S_FINAL: begin
                o_push = i_can_push;
                o_res  = r_res;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_chk   <= 1'b0;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_chk   <= n_chk;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
        end
    end

    // operands and pending result
    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_src       <= n_src;
        r_dst       <= n_dst;
        r_cost      <= n_cost;
        r_chk_idx   <= n_chk_idx;
        r_pend_node <= n_pend_node;
        r_pend_cost <= n_pend_cost;
        r_res       <= n_res;
    end

endmodule

// File: rtl/adjacency_matrix_edge_table.sv
// ----------------------------------------------------------------------------
// adjacency_matrix_edge_table
// directed graph held as a square memory of signed edge costs
// ----------------------------------------------------------------------------
// Use: one operation word enters on the slave stream (tuser selects insert,
// remove, test, in-degree, out-degree or neighbour list), results leave on
// the master stream, tlast on the final word of each operation. A listing
// gives one word per out-neighbour in ascending node order, or one word with
// status no-neighbours. Operation codes six and seven are taken and dropped.
// The configuration channel sets node_count; write it only while idle.
// Sequence: insert, remove and test read the entry, then write it back and
// push the result once the output register has room; the next word is taken
// in the cycle after the push. Degree and list queries scan one row or column
// entry per cycle through the single memory read port unless a listing stalls.
// Operations run one at a time; the next word is taken once the result of
// the current one sits in the output register.
// A stall on the master stream holds the output register; a listing waits
// with its scan until the register can take the next neighbour word.
// Reset: node_count returns to 16 and all entries read as no edge at once
// (per-entry valid bits), so the block takes words right after reset.
// ----------------------------------------------------------------------------
module adjacency_matrix_edge_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // src_node, dst_node, edge_cost
    input  logic [2:0]  s_axis_tuser,   // func
    // master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // is_edge, degree, neighbour_node,
                                        // neighbour_cost, zero fill
    output logic [2:0]  m_axis_tuser,   // status
    output logic        m_axis_tlast,   // last_item
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data      // node_count
);
    import amet_pkg::*;

    logic [4:0]            r_eff_n;
    t_mem_req              w_mem;
    logic [COST_WIDTH-1:0] w_rd_data;
    logic                  w_push;
    logic                  w_can_push;
    t_result               w_res;
    t_result               w_out;

    // node count register, kept already limited
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_n <= eff_count(NODE_COUNT_RST);
        end else if (i_cfg_valid) begin
            r_eff_n <= eff_count(i_cfg_data);
        end
    end

    amet_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_func     (s_axis_tuser),
        .i_src      (s_axis_tdata[3:0]),
        .i_dst      (s_axis_tdata[7:4]),
        .i_cost     (s_axis_tdata[23:8]),
        .i_eff_n    (r_eff_n),
        .o_mem      (w_mem),
        .i_rd_data  (w_rd_data),
        .o_push     (w_push),
        .o_res      (w_res),
        .i_can_push (w_can_push)
    );

    amet_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_mem),
        .o_rd_data (w_rd_data)
    );

    amet_outreg u_outreg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_res      (w_res),
        .o_can_push (w_can_push),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_res      (w_out)
    );

    // result word packing
    assign m_axis_tdata = {6'd0, w_out.nb_cost, w_out.nb_node, w_out.degree,
                           w_out.is_edge};
    assign m_axis_tuser = w_out.status;
    assign m_axis_tlast = w_out.last;

endmodule

// File: rtl/amet_checker.sv
// ----------------------------------------------------------------------------
// amet_checker
// port-level checks of the edge table, bound to the top level
// ----------------------------------------------------------------------------
`include "adjacency_matrix_edge_table_assert.svh"

module amet_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import amet_pkg::*;

    // a stalled result word holds
    `AMET_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result word changed")

    // only listed neighbours come without tlast, and they carry a cost
    `AMET_ASSERT_NOW(a_mid_list, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast, (m_axis_tuser == ST_OK) && (m_axis_tdata[25:10] != 16'd0) && (m_axis_tdata[5:0] == 6'd0), "non-final word is not a neighbour")

    // an invalid node gives one bare word
    `AMET_ASSERT_NOW(a_invalid, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == ST_INVALID), m_axis_tlast && (m_axis_tdata == 32'd0), "invalid node word carries data")

    // one operation at a time: a real operation closes the slave side
    `AMET_ASSERT_NEXT(a_one_op, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser <= 3'(FN_LIST)), !s_axis_tready, "word taken while an operation runs")

endmodule

bind adjacency_matrix_edge_table amet_checker u_amet_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: tb/sv/tb_adjacency_matrix_edge_table.sv
// ----------------------------------------------------------------------------
// tb_adjacency_matrix_edge_table
// self-checking bench for the directed graph edge table
// ----------------------------------------------------------------------------
// Operation words go in on the slave stream and result words are checked on
// the master stream against a behavioral model of the cost matrix kept in
// the bench. A directed table covers empty-graph queries, extreme costs,
// overwrite and clear on insert, absent removes, invalid nodes and the
// spare operation codes. Random traffic follows under three idle profiles,
// with node_count stepped through small, full and out-of-range settings.
// ----------------------------------------------------------------------------
module tb_adjacency_matrix_edge_table;

    timeunit 1ns;
    timeprecision 1ps;

    import amet_pkg::*;

    // spare operation codes, dropped by the block
    localparam logic [2:0] FN_SPARE6 = 3'd6;
    localparam logic [2:0] FN_SPARE7 = 3'd7;

    localparam int TAIL_CYCLES  = 24;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_WORDS = 405;
    localparam int SEGMENTS     = 9;
    localparam int DIR_ROWS     = 29;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [4:0]  i_cfg_data;

    adjacency_matrix_edge_table DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // bench copy of the graph and the node count
    logic [15:0] cost_table [16][16];
    logic [4:0]  live_nodes;
    t_result     pending_words [$];

    int src_idle_pct;
    int sink_idle_pct;
    int mismatches;
    int idle_cycles;

    // one directed stimulus row: a node_count write or an operation word
    typedef struct packed {
        logic        is_cfg;
        logic [4:0]  cfg_val;
        logic [2:0]  func;
        logic [3:0]  src;
        logic [3:0]  dst;
        logic [15:0] cost;
        logic        typed;
        t_status     st;
        logic        is_edge;
        logic [4:0]  degree;
    } t_row;

    t_row dir_tab [DIR_ROWS];

    // expected result words of one operation word
    task automatic forecast_op(input logic [2:0] fn, input logic [3:0] src,
                               input logic [3:0] dst, input logic [15:0] cost);
        int      n;
        int      cnt;
        int      last_col;
        logic    src_ok;
        logic    dst_ok;
        logic [15:0] old;
        t_result w;
        n = (live_nodes > 5'd16) ? 16 : int'(live_nodes);
        src_ok = int'(src) < n;
        dst_ok = int'(dst) < n;
        w = '0;
        w.status = ST_OK;
        w.last = 1'b1;
        if (fn == FN_SPARE6 || fn == FN_SPARE7) begin
            return;
        end
        // edge operations need both nodes, queries only the source
        if ((fn == FN_INSERT || fn == FN_REMOVE || fn == FN_TEST) ? !(src_ok && dst_ok)
                                                                   : !src_ok) begin
            w.status = ST_INVALID;
            pending_words.push_back(w);
            return;
        end
        old = cost_table[src][dst];
        case (fn)
            FN_INSERT: begin
                cost_table[src][dst] = cost;
                w.status = (old != 16'd0) ? ST_REPLACED : ST_OK;
                pending_words.push_back(w);
            end
            FN_REMOVE: begin
                if (old == 16'd0) begin
                    w.status = ST_ABSENT;
                end else begin
                    cost_table[src][dst] = 16'd0;
                end
                pending_words.push_back(w);
            end
            FN_TEST: begin
                w.is_edge = (old != 16'd0);
                pending_words.push_back(w);
            end
            FN_INDEG, FN_OUTDEG: begin
                cnt = 0;
                for (int i = 0; i < n; i++) begin
                    if (fn == FN_INDEG ? cost_table[i][src] != 16'd0
                                       : cost_table[src][i] != 16'd0) begin
                        cnt++;
                    end
                end
                w.degree = 5'(cnt);
                pending_words.push_back(w);
            end
            default: begin
                // neighbour listing in ascending column order
                last_col = -1;
                for (int i = 0; i < n; i++) begin
                    if (cost_table[src][i] != 16'd0) begin
                        last_col = i;
                    end
                end
                if (last_col < 0) begin
                    w.status = ST_NONE;
                    pending_words.push_back(w);
                end else begin
                    for (int i = 0; i <= last_col; i++) begin
                        if (cost_table[src][i] != 16'd0) begin
                            w = '0;
                            w.status = ST_OK;
                            w.nb_node = 4'(i);
                            w.nb_cost = cost_table[src][i];
                            w.last = (i == last_col);
                            pending_words.push_back(w);
                        end
                    end
                end
            end
        endcase
    endtask

    // drive one operation word; entered and left at a falling edge
    task automatic send_word(input logic [2:0] fn, input logic [3:0] src,
                             input logic [3:0] dst, input logic [15:0] cost,
                             input logic typed, input t_result typed_word);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cost, dst, src};
        s_axis_tuser  <= fn;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        forecast_op(fn, src, dst, cost);
        // a hand-typed expectation takes the place of the predicted word
        if (typed) begin
            void'(pending_words.pop_back());
            pending_words.push_back(typed_word);
        end
        @(negedge i_clk);
    endtask

    // hold the sender until every expected word is back and the block is idle
    task automatic settle_results();
        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    // node_count write, only with the block idle
    task automatic write_node_count(input logic [4:0] val);
        settle_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        live_nodes = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // random operation word, mostly on nodes in use
    task automatic send_random(output logic counted);
        int          n;
        int          r;
        logic [2:0]  fn;
        logic [3:0]  src;
        logic [3:0]  dst;
        logic [15:0] cost;
        n = (live_nodes > 5'd16) ? 16 : int'(live_nodes);
        r = $urandom_range(0, 99);
        if (r < 35)      fn = FN_INSERT;
        else if (r < 45) fn = FN_REMOVE;
        else if (r < 58) fn = FN_TEST;
        else if (r < 68) fn = FN_INDEG;
        else if (r < 78) fn = FN_OUTDEG;
        else if (r < 94) fn = FN_LIST;
        else             fn = ($urandom_range(0, 1) != 0) ? FN_SPARE7 : FN_SPARE6;
        if (n > 0 && $urandom_range(0, 9) != 0) begin
            src = 4'($urandom_range(0, n - 1));
            dst = 4'($urandom_range(0, n - 1));
        end else begin
            src = 4'($urandom_range(0, 15));
            dst = 4'($urandom_range(0, 15));
        end
        case ($urandom_range(0, 9))
            0:       cost = 16'h0000;
            1:       cost = 16'h7fff;
            2:       cost = 16'h8000;
            3:       cost = 16'hffff;
            default: cost = 16'($urandom());
        endcase
        counted = !(fn == FN_SPARE6 || fn == FN_SPARE7);
        send_word(fn, src, dst, cost, 1'b0, '0);
    endtask

    // sink side ready, randomly withheld
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // result check against the oldest expected word
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status  = t_status'(m_axis_tuser);
            got.is_edge = m_axis_tdata[0];
            got.degree  = m_axis_tdata[5:1];
            got.nb_node = m_axis_tdata[9:6];
            got.nb_cost = m_axis_tdata[25:10];
            got.last    = m_axis_tlast;
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected word: status %0d edge %0d deg %0d nb %0d cost %h last %0d",
                             got.status, got.is_edge, got.degree, got.nb_node,
                             got.nb_cost, got.last);
                end
            end else begin
                want = pending_words.pop_front();
                if (got != want || m_axis_tdata[31:26] != 6'd0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at %0t: exp status %0d edge %0d deg %0d nb %0d cost %h last %0d",
                                 $realtime, want.status, want.is_edge, want.degree,
                                 want.nb_node, want.nb_cost, want.last);
                        $display("                 got status %0d edge %0d deg %0d nb %0d cost %h last %0d fill %h",
                                 got.status, got.is_edge, got.degree, got.nb_node,
                                 got.nb_cost, got.last, m_axis_tdata[31:26]);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no word moved on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n ||
            (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // directed rows: cfg, value, func, src, dst, cost, typed, status, edge, degree
    initial begin
        dir_tab[0]  = '{1'b0, 5'd0,  FN_TEST,   4'd0,  4'd0,  16'h0000, 1'b1, ST_OK,       1'b0, 5'd0};
        dir_tab[1]  = '{1'b0, 5'd0,  FN_LIST,   4'd0,  4'd0,  16'h0000, 1'b1, ST_NONE,     1'b0, 5'd0};
        dir_tab[2]  = '{1'b0, 5'd0,  FN_OUTDEG, 4'd0,  4'd0,  16'h0000, 1'b1, ST_OK,       1'b0, 5'd0};
        dir_tab[3]  = '{1'b0, 5'd0,  FN_INDEG,  4'd15, 4'd0,  16'h0000, 1'b1, ST_OK,       1'b0, 5'd0};
        dir_tab[4]  = '{1'b0, 5'd0,  FN_REMOVE, 4'd3,  4'd4,  16'h0000, 1'b1, ST_ABSENT,   1'b0, 5'd0};
        dir_tab[5]  = '{1'b0, 5'd0,  FN_INSERT, 4'd0,  4'd15, 16'h7fff, 1'b1, ST_OK,       1'b0, 5'd0};
        dir_tab[6]  = '{1'b0, 5'd0,  FN_INSERT, 4'd0,  4'd0,  16'h8000, 1'b1, ST_OK,       1'b0, 5'd0};
        dir_tab[7]  = '{1'b0, 5'd0,  FN_INSERT, 4'd0,  4'd0,  16'h0001, 1'b1, ST_REPLACED, 1'b0, 5'd0};
        dir_tab[8]  = '{1'b0, 5'd0,  FN_INSERT, 4'd0,  4'd5,  16'hffff, 1'b0, ST_OK,       1'b0, 5'd0};
        dir_tab[9]  = '{1'b0, 5'd0,  FN_INSERT, 4'd15, 4'd0,  16'h0000, 1'b1, ST_OK,       1'b0, 5'd0};
        dir_tab[10] = '{1'b0, 5'd0,  FN_INSERT, 4'd0,  4'd0,  16'h0000, 1'b1, ST_REPLACED, 1'b0, 5'd0};
        dir_tab[11] = '{1'b0, 5'd0,  FN_TEST,   4'd0,  4'd15, 16'h0000, 1'b0, ST_OK,       1'b0, 5'd0};
        dir_tab[12] = '{1'b0, 5'd0,  FN_LIST,   4'd0,  4'd0,  16'h0000, 1'b0, ST_OK,       1'b0, 5'd0};
        dir_tab[13] = '{1'b0, 5'd0,  FN_OUTDEG, 4'd0,  4'd0,  16'h0000, 1'b0, ST_OK,       1'b0, 5'd0};
        dir_tab[14] = '{1'b0, 5'd0,  FN_INDEG,  4'd15, 4'd0,  16'h0000, 1'b0, ST_OK,       1'b0, 5'd0};
        dir_tab[15] = '{1'b0, 5'd0,  FN_REMOVE, 4'd0,  4'd5,  16'h0000, 1'b1, ST_OK,       1'b0, 5'd0};
        dir_tab[16] = '{1'b0, 5'd0,  FN_SPARE6, 4'd15, 4'd15, 16'hffff, 1'b0, ST_OK,       1'b0, 5'd0};
        dir_tab[17] = '{1'b0, 5'd0,  FN_SPARE7, 4'd1,  4'd2,  16'h1234, 1'b0, ST_OK,       1'b0, 5'd0};
        dir_tab[18] = '{1'b1, 5'd4,  FN_INSERT, 4'd0,  4'd0,  16'h0000, 1'b0, ST_OK,       1'b0, 5'd0};
        dir_tab[19] = '{1'b0, 5'd0,  FN_LIST,   4'd5,  4'd0,  16'h0000, 1'b1, ST_INVALID,  1'b0, 5'd0};
        dir_tab[20] = '{1'b0, 5'd0,  FN_INSERT, 4'd2,  4'd9,  16'h0042, 1'b1, ST_INVALID,  1'b0, 5'd0};
        dir_tab[21] = '{1'b0, 5'd0,  FN_TEST,   4'd9,  4'd1,  16'h0000, 1'b1, ST_INVALID,  1'b0, 5'd0};
        dir_tab[22] = '{1'b0, 5'd0,  FN_INDEG,  4'd4,  4'd0,  16'h0000, 1'b1, ST_INVALID,  1'b0, 5'd0};
        dir_tab[23] = '{1'b0, 5'd0,  FN_OUTDEG, 4'd15, 4'd0,  16'h0000, 1'b1, ST_INVALID,  1'b0, 5'd0};
        dir_tab[24] = '{1'b0, 5'd0,  FN_LIST,   4'd0,  4'd0,  16'h0000, 1'b0, ST_OK,       1'b0, 5'd0};
        dir_tab[25] = '{1'b1, 5'd0,  FN_INSERT, 4'd0,  4'd0,  16'h0000, 1'b0, ST_OK,       1'b0, 5'd0};
        dir_tab[26] = '{1'b0, 5'd0,  FN_TEST,   4'd0,  4'd0,  16'h0000, 1'b1, ST_INVALID,  1'b0, 5'd0};
        dir_tab[27] = '{1'b1, 5'd31, FN_INSERT, 4'd0,  4'd0,  16'h0000, 1'b0, ST_OK,       1'b0, 5'd0};
        dir_tab[28] = '{1'b0, 5'd0,  FN_LIST,   4'd0,  4'd0,  16'h0000, 1'b0, ST_OK,       1'b0, 5'd0};
    end

    // main sequence
    initial begin
        t_result     typed_word;
        logic        counted;
        int          sent;
        logic [4:0]  seg_count [SEGMENTS];
        seg_count = '{5'd16, 5'd1, 5'd7, 5'd31, 5'd0, 5'd16, 5'd2, 5'd12, 5'd16};
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        mismatches    = 0;
        src_idle_pct  = 6;
        sink_idle_pct = 55;
        live_nodes    = 5'd16;
        for (int r = 0; r < 16; r++) begin
            for (int c = 0; c < 16; c++) begin
                cost_table[r][c] = 16'd0;
            end
        end
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        for (int k = 0; k < DIR_ROWS; k++) begin
            if (dir_tab[k].is_cfg) begin
                write_node_count(dir_tab[k].cfg_val);
            end else begin
                typed_word = '0;
                typed_word.status  = dir_tab[k].st;
                typed_word.is_edge = dir_tab[k].is_edge;
                typed_word.degree  = dir_tab[k].degree;
                typed_word.last    = 1'b1;
                send_word(dir_tab[k].func, dir_tab[k].src, dir_tab[k].dst,
                          dir_tab[k].cost, dir_tab[k].typed, typed_word);
            end
        end

        // random traffic, three idle profiles of three segments each
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg / 3 == 0) begin
                src_idle_pct  = 6;
                sink_idle_pct = 55;
            end else if (seg / 3 == 1) begin
                src_idle_pct  = 55;
                sink_idle_pct = 6;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            write_node_count(seg_count[seg]);
            sent = 0;
            while (sent < RANDOM_WORDS / SEGMENTS) begin
                if ($urandom_range(0, 39) == 0) begin
                    settle_results();
                end
                send_random(counted);
                if (counted) sent++;
            end
        end

        settle_results();
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/amet_pkg.sv
rtl/amet_store.sv
rtl/amet_outreg.sv
rtl/amet_ctrl.sv
rtl/adjacency_matrix_edge_table.sv
rtl/amet_checker.sv
tb/sv/tb_adjacency_matrix_edge_table.sv
